// File: src/ascii_framed_packet_receiver_macros.svh
// Assertion macros shared by the deframer RTL.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef ASCII_FRAMED_PACKET_RECEIVER_MACROS_SVH
`define ASCII_FRAMED_PACKET_RECEIVER_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define AFPR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define AFPR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/afpr_pkg.sv
// Package of the ASCII framed packet receiver: field widths, codes, reset values
// and the command, status and result types. No dependencies.
package afpr_pkg;

  localparam int OPCODE_W   = 2;
  localparam int BYTE_W     = 8;
  localparam int ERR_W      = 2;
  localparam int KIND_W     = 2;
  localparam int PTYPE_W    = 7;
  localparam int DLEN_W     = 4;
  localparam int IDX_W      = 4;
  localparam int DEC_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TIMER_W    = 16;

  localparam int MAX_PAYLOAD_DEF = 10;
  localparam int FRAME_DEPTH_DEF = 16;

  localparam logic [BYTE_W-1:0]  OPEN_CODE_RST     = 8'h02;
  localparam logic [BYTE_W-1:0]  END_CODE_RST      = 8'h03;
  localparam logic               GENERAL_MODE_RST  = 1'b0;
  localparam logic [TIMER_W-1:0] FRAME_TIMEOUT_RST = 16'd2000;
  localparam logic [TIMER_W-1:0] LINK_TIMEOUT_RST  = 16'd2000;

  localparam logic [BYTE_W-1:0] ASCII_ZERO     = 8'h30;
  localparam logic [DEC_W-1:0]  DEC_RADIX      = 7'd10;
  localparam int                FRAME_OVERHEAD = 6;
  localparam int                PAYLOAD_OFFSET = 5;
  localparam int                HDR_BYTES      = 4;

  // Type/length pairs accepted when general mode is off.
  localparam logic [DEC_W-1:0] FIX_TYPE_A = 7'd1;
  localparam logic [DEC_W-1:0] FIX_LEN_A  = 7'd3;
  localparam logic [DEC_W-1:0] FIX_TYPE_B = 7'd0;
  localparam logic [DEC_W-1:0] FIX_LEN_B  = 7'd6;

  typedef enum logic [OPCODE_W-1:0] {
    OP_BYTE     = 2'd0,
    OP_TICK     = 2'd1,
    OP_LINE_ERR = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA      = 2'd0,
    KIND_BAD_FRAME = 2'd1,
    KIND_LINE_ERR  = 2'd2,
    KIND_OFFLINE   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OPEN_CODE     = 3'd0,
    REG_END_CODE      = 3'd1,
    REG_GENERAL_MODE  = 3'd2,
    REG_FRAME_TIMEOUT = 3'd3,
    REG_LINK_TIMEOUT  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_LOAD = 2'd2
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;      // process the buffered item
    logic rd;        // read the next payload byte from the frame store
    logic load_run;  // move the read payload byte into the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic item_valid;  // an item waits in the input buffer
    logic out_busy;    // the result register holds an untaken item
    logic start_run;   // the buffered item closes a good frame with payload
    logic run_last;    // the current payload byte is the last of the run
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic [PTYPE_W-1:0] ptype;
    logic [DLEN_W-1:0]  dlen;
    logic [BYTE_W-1:0]  dbyte;
    logic [IDX_W-1:0]   idx;
    logic               last;
    logic               online;
    logic [ERR_W-1:0]   err;
  } out_item_t;

endpackage

// File: src/afpr_if.sv
// Valid/ready channel interfaces for the input and result items of the deframer.
// Depends on afpr_pkg.
interface afpr_in_if;
  import afpr_pkg::*;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [BYTE_W-1:0]   rx_byte;
  logic [ERR_W-1:0]    error_bits;

  modport source (output valid, output opcode, output rx_byte, output error_bits,
                  input ready);
  modport sink (input valid, input opcode, input rx_byte, input error_bits,
                output ready);
endinterface

interface afpr_out_if;
  import afpr_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [PTYPE_W-1:0] packet_type;
  logic [DLEN_W-1:0]  data_length;
  logic [BYTE_W-1:0]  data_byte;
  logic [IDX_W-1:0]   byte_index;
  logic               last;
  logic               online;
  logic [ERR_W-1:0]   error_code;

  modport source (output valid, output kind, output packet_type, output data_length,
                  output data_byte, output byte_index, output last, output online,
                  output error_code, input ready);
  modport sink (input valid, input kind, input packet_type, input data_length,
                input data_byte, input byte_index, input last, input online,
                input error_code, output ready);
endinterface

// File: src/afpr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module afpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/afpr_ctrl.sv
// Controller of the deframer: sequences item execution and payload runs.
// Depends on afpr_pkg and the assertion macro header.
`include "ascii_framed_packet_receiver_macros.svh"

module afpr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  afpr_pkg::status_t status,
  output afpr_pkg::cmd_t    cmd
);
  import afpr_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (status.item_valid && !status.out_busy && status.start_run) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (!status.out_busy) begin
          state_nxt = status.run_last ? ST_IDLE : ST_READ;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: cmd.exec     = status.item_valid && !status.out_busy;
      ST_READ: cmd.rd       = 1'b1;
      ST_LOAD: cmd.load_run = !status.out_busy;
      default: cmd = '0;
    endcase
  end

  // A byte is only presented after its read has been issued.
  `AFPR_ASSERT_IMP(a_load_after_read, state_r == ST_LOAD,
    $past(state_r) == ST_READ || $past(state_r) == ST_LOAD, "load without read")
  // A run ends only through its last byte.
  `AFPR_ASSERT_NXT(a_run_ends_last, state_r == ST_LOAD && state_nxt == ST_IDLE,
    $past(status.run_last), "run left before its last byte")

endmodule

// File: src/afpr_datapath.sv
// Datapath of the deframer: input buffer, configuration, frame and link state,
// frame store, frame check and result register. Depends on afpr_pkg, afpr_if,
// afpr_ram and the assertion macro header.
`include "ascii_framed_packet_receiver_macros.svh"

module afpr_datapath #(
  parameter int MAX_PAYLOAD = afpr_pkg::MAX_PAYLOAD_DEF,
  parameter int FRAME_DEPTH = afpr_pkg::FRAME_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [afpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [afpr_pkg::CFG_DATA_W-1:0] cfg_data,
  afpr_in_if.sink                         in_ch,
  afpr_out_if.source                      out_ch,
  input  afpr_pkg::cmd_t                  cmd,
  output afpr_pkg::status_t               status
);
  import afpr_pkg::*;

  localparam int AW = $clog2(FRAME_DEPTH);
  localparam int CW = $clog2(FRAME_DEPTH + 1);

  function automatic logic is_digit(input logic [BYTE_W-1:0] b);
    is_digit = (b >= ASCII_ZERO) && (b <= ASCII_ZERO + 8'd9);
  endfunction

  // Configuration registers.
  logic [BYTE_W-1:0]  open_code_r;
  logic [BYTE_W-1:0]  end_code_r;
  logic               general_mode_r;
  logic [TIMER_W-1:0] frame_timeout_r;
  logic [TIMER_W-1:0] link_timeout_r;

  // Input buffer.
  logic              item_valid_r, item_valid_nxt;
  op_t               item_op_r;
  logic [BYTE_W-1:0] item_byte_r;
  logic [ERR_W-1:0]  item_err_r;

  // Frame and link state.
  logic               receiving_r, receiving_nxt;
  logic               link_online_r, link_online_nxt;
  logic [TIMER_W-1:0] frame_cd_r, frame_cd_nxt;
  logic [TIMER_W-1:0] link_cd_r, link_cd_nxt;
  logic [CW-1:0]      frame_count_r, frame_count_nxt;
  logic               frame_ovf_r, frame_ovf_nxt;
  logic [BYTE_W-1:0]  hdr_r [HDR_BYTES];
  logic [BYTE_W-1:0]  hdr_nxt [HDR_BYTES];

  // Payload run.
  logic [DEC_W-1:0] run_idx_r, run_idx_nxt;
  logic [DEC_W-1:0] run_len_r, run_len_nxt;
  logic [DEC_W-1:0] run_ptype_r, run_ptype_nxt;
  logic             run_last;

  // Result register.
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;

  // Frame store.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic [BYTE_W-1:0] rd_sum;

  // Frame check of the buffered byte as if it closes the frame.
  logic             store_ok;
  logic [CW-1:0]    cnt_after;
  logic             ovf_after;
  logic             hdr_ok;
  logic [DEC_W-1:0] ptype;
  logic [DEC_W-1:0] dlen;
  logic             pair_ok;
  logic             len_ok;
  logic             frame_good;
  logic             closes;

  always_comb begin
    store_ok  = frame_count_r < CW'(FRAME_DEPTH);
    cnt_after = store_ok ? frame_count_r + CW'(1) : frame_count_r;
    ovf_after = frame_ovf_r || !store_ok;
    hdr_ok    = is_digit(hdr_r[0]) && is_digit(hdr_r[1]) &&
                is_digit(hdr_r[2]) && is_digit(hdr_r[3]);
    ptype     = DEC_W'(hdr_r[0][3:0]) * DEC_RADIX + DEC_W'(hdr_r[1][3:0]);
    dlen      = DEC_W'(hdr_r[2][3:0]) * DEC_RADIX + DEC_W'(hdr_r[3][3:0]);
    if (general_mode_r) begin
      pair_ok = dlen <= DEC_W'(MAX_PAYLOAD);
    end else begin
      pair_ok = (ptype == FIX_TYPE_A && dlen == FIX_LEN_A) ||
                (ptype == FIX_TYPE_B && dlen == FIX_LEN_B);
    end
    len_ok     = 8'(cnt_after) == ({1'b0, dlen} + 8'(FRAME_OVERHEAD));
    frame_good = !ovf_after && (cnt_after >= CW'(FRAME_OVERHEAD)) &&
                 hdr_ok && pair_ok && len_ok;
    closes     = receiving_r && (item_byte_r == end_code_r);
  end

  assign run_last = (run_idx_r + DEC_W'(1)) == run_len_r;
  assign rd_sum   = 8'(PAYLOAD_OFFSET) + {1'b0, run_idx_r};

  assign status.item_valid = item_valid_r;
  assign status.out_busy   = out_valid_r;
  assign status.start_run  = (item_op_r == OP_BYTE) && closes && frame_good &&
                             (dlen != '0);
  assign status.run_last   = run_last;

  afpr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FRAME_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (item_byte_r),
    .re    (cmd.rd),
    .raddr (rd_sum[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    item_valid_nxt  = item_valid_r;
    receiving_nxt   = receiving_r;
    link_online_nxt = link_online_r;
    frame_cd_nxt    = frame_cd_r;
    link_cd_nxt     = link_cd_r;
    frame_count_nxt = frame_count_r;
    frame_ovf_nxt   = frame_ovf_r;
    hdr_nxt         = hdr_r;
    run_idx_nxt     = run_idx_r;
    run_len_nxt     = run_len_r;
    run_ptype_nxt   = run_ptype_r;
    out_valid_nxt   = out_valid_r;
    out_nxt         = out_r;
    ram_we          = 1'b0;
    ram_waddr       = frame_count_r[AW-1:0];

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_ch.valid && !item_valid_r) begin
      item_valid_nxt = 1'b1;
    end

    if (cmd.exec) begin
      item_valid_nxt = 1'b0;
      unique case (item_op_r)
        OP_BYTE: begin
          if (!receiving_r) begin
            if (item_byte_r == open_code_r) begin
              ram_we          = 1'b1;
              ram_waddr       = '0;
              frame_count_nxt = CW'(1);
              frame_ovf_nxt   = 1'b0;
              frame_cd_nxt    = frame_timeout_r;
              receiving_nxt   = 1'b1;
            end
          end else begin
            if (store_ok) begin
              ram_we          = 1'b1;
              frame_count_nxt = cnt_after;
              for (int k = 0; k < HDR_BYTES; k++) begin
                if (frame_count_r == CW'(k + 1)) begin
                  hdr_nxt[k] = item_byte_r;
                end
              end
            end else begin
              frame_ovf_nxt = 1'b1;
            end
            if (closes) begin
              receiving_nxt   = 1'b0;
              frame_count_nxt = '0;
              frame_ovf_nxt   = 1'b0;
              if (frame_good) begin
                link_online_nxt = 1'b1;
                link_cd_nxt     = link_timeout_r;
                if (dlen == '0) begin
                  out_valid_nxt = 1'b1;
                  out_nxt = '{kind: KIND_DATA, ptype: ptype, dlen: '0, dbyte: '0,
                              idx: '0, last: 1'b1, online: 1'b1, err: '0};
                end else begin
                  run_idx_nxt   = '0;
                  run_len_nxt   = dlen;
                  run_ptype_nxt = ptype;
                end
              end else begin
                out_valid_nxt = 1'b1;
                out_nxt = '{kind: KIND_BAD_FRAME, ptype: '0, dlen: '0, dbyte: '0,
                            idx: '0, last: 1'b1, online: link_online_r, err: '0};
              end
            end
          end
        end
        OP_TICK: begin
          if (receiving_r) begin
            if (frame_cd_r <= TIMER_W'(1)) begin
              frame_cd_nxt    = '0;
              receiving_nxt   = 1'b0;
              frame_count_nxt = '0;
              frame_ovf_nxt   = 1'b0;
            end else begin
              frame_cd_nxt = frame_cd_r - TIMER_W'(1);
            end
          end
          if (link_online_r) begin
            if (link_cd_r == '0) begin
              link_online_nxt = 1'b0;
              out_valid_nxt   = 1'b1;
              out_nxt = '{kind: KIND_OFFLINE, ptype: '0, dlen: '0, dbyte: '0,
                          idx: '0, last: 1'b1, online: 1'b0, err: '0};
            end else begin
              link_cd_nxt = link_cd_r - TIMER_W'(1);
            end
          end
        end
        OP_LINE_ERR: begin
          if (item_err_r != '0) begin
            out_valid_nxt = 1'b1;
            out_nxt = '{kind: KIND_LINE_ERR, ptype: '0, dlen: '0, dbyte: '0,
                        idx: '0, last: 1'b1, online: link_online_r, err: item_err_r};
          end
        end
        OP_NONE: ;
        default: ;
      endcase
    end

    if (cmd.load_run) begin
      out_valid_nxt = 1'b1;
      out_nxt = '{kind: KIND_DATA, ptype: run_ptype_r, dlen: run_len_r[DLEN_W-1:0],
                  dbyte: ram_rdata, idx: run_idx_r[IDX_W-1:0], last: run_last,
                  online: link_online_r, err: '0};
      run_idx_nxt = run_idx_r + DEC_W'(1);
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_code_r     <= OPEN_CODE_RST;
      end_code_r      <= END_CODE_RST;
      general_mode_r  <= GENERAL_MODE_RST;
      frame_timeout_r <= FRAME_TIMEOUT_RST;
      link_timeout_r  <= LINK_TIMEOUT_RST;
      item_valid_r    <= 1'b0;
      receiving_r     <= 1'b0;
      link_online_r   <= 1'b0;
      frame_cd_r      <= '0;
      link_cd_r       <= '0;
      frame_count_r   <= '0;
      frame_ovf_r     <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OPEN_CODE:     open_code_r     <= cfg_data[BYTE_W-1:0];
          REG_END_CODE:      end_code_r      <= cfg_data[BYTE_W-1:0];
          REG_GENERAL_MODE:  general_mode_r  <= cfg_data[0];
          REG_FRAME_TIMEOUT: frame_timeout_r <= cfg_data[TIMER_W-1:0];
          REG_LINK_TIMEOUT:  link_timeout_r  <= cfg_data[TIMER_W-1:0];
          default: ;
        endcase
      end
      item_valid_r  <= item_valid_nxt;
      receiving_r   <= receiving_nxt;
      link_online_r <= link_online_nxt;
      frame_cd_r    <= frame_cd_nxt;
      link_cd_r     <= link_cd_nxt;
      frame_count_r <= frame_count_nxt;
      frame_ovf_r   <= frame_ovf_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ch.valid && !item_valid_r) begin
      item_op_r   <= op_t'(in_ch.opcode);
      item_byte_r <= in_ch.rx_byte;
      item_err_r  <= in_ch.error_bits;
    end
    hdr_r       <= hdr_nxt;
    run_idx_r   <= run_idx_nxt;
    run_len_r   <= run_len_nxt;
    run_ptype_r <= run_ptype_nxt;
    out_r       <= out_nxt;
  end

  assign in_ch.ready        = !item_valid_r;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_r.kind;
  assign out_ch.packet_type = out_r.ptype;
  assign out_ch.data_length = out_r.dlen;
  assign out_ch.data_byte   = out_r.dbyte;
  assign out_ch.byte_index  = out_r.idx;
  assign out_ch.last        = out_r.last;
  assign out_ch.online      = out_r.online;
  assign out_ch.error_code  = out_r.err;

  `AFPR_ASSERT_IMP(a_no_overwrite, cmd.exec || cmd.load_run, !out_valid_r,
    "result register loaded while full")
  `AFPR_ASSERT_IMP(a_recv_count, receiving_r, frame_count_r != '0,
    "receiving with an empty frame")
  `AFPR_ASSERT_IMP(a_idle_clean, !receiving_r, frame_count_r == '0 && !frame_ovf_r,
    "frame state left over in idle")
  `AFPR_ASSERT_IMP(a_run_in_range, cmd.load_run, run_idx_r < run_len_r,
    "payload index beyond run length")

endmodule

// File: src/ascii_framed_packet_receiver.sv
// An accepted item waits in the one-item input buffer and executes once the result register
// is free; its result is then registered there. A payload run starts after its end code
// executes. The input buffer takes no new item until the buffered one has executed; each
// payload byte takes a store read, then a result load, and an item with results holds off
// execution of the next until its last result is taken.
// Reset (rst_n, synchronous, active low) clears control state and configuration only.
module ascii_framed_packet_receiver #(
  parameter int MAX_PAYLOAD = afpr_pkg::MAX_PAYLOAD_DEF,
  parameter int FRAME_DEPTH = afpr_pkg::FRAME_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [afpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [afpr_pkg::CFG_DATA_W-1:0] cfg_data,
  afpr_in_if.sink                         in_ch,
  afpr_out_if.source                      out_ch
);
  import afpr_pkg::*;

  // The controller decides when the buffered item is executed and walks
  // through a payload run one byte at a time. The datapath holds everything
  // else: the one-item input buffer, the configuration registers, the frame
  // and link timers, the header digit registers, the frame store and the
  // result register. The frame store holds undefined data after reset and
  // needs no clearing pass, since only bytes of the current frame are read.
  cmd_t    cmd;
  status_t status;

  // An input item is taken whenever the input buffer is empty, so a new item
  // is accepted while a finished result still waits on the output channel.
  // The buffered item is executed only once the result register is free,
  // because every item may produce a result.
  afpr_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  // Frame bytes are written to the frame store as they arrive; the four
  // header digits are also kept in registers so that the frame check at the
  // end code is combinational logic. A good frame with payload starts a run: each
  // byte is read from the store and presented with its index, the last byte
  // carrying the last flag.
  afpr_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the ASCII framed packet receiver (deframer).
// It drives bytes, ticks and line errors, predicts every result, and compares
// them in order. Depends on afpr_pkg, the afpr_in_if/afpr_out_if interfaces and the RTL.
module testbench;
  import afpr_pkg::*;

  localparam int FRAME_DEPTH   = FRAME_DEPTH_DEF;
  localparam int MAX_PAYLOAD   = MAX_PAYLOAD_DEF;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_REPORTS   = 40;

  // Ways to build a frame: one well formed shape and the broken ones.
  typedef enum int {
    FRAME_GOOD,
    FRAME_SHORT,
    FRAME_NONDIGIT,
    FRAME_WRONG_LEN,
    FRAME_OVERLONG,
    FRAME_BAD_PAIR
  } frame_shape_t;

  // One item for the input channel. The drain flag makes the sender wait until
  // every result expected so far has been taken before it offers this item.
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [BYTE_W-1:0]   rx_byte;
    logic [ERR_W-1:0]    error_bits;
    logic                drain;
  } line_event_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  afpr_in_if  in_ch ();
  afpr_out_if out_ch ();

  ascii_framed_packet_receiver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Items waiting to be offered, and results the deframer is expected to produce.
  line_event_t rx_events[$];
  out_item_t   expected_results[$];

  int  cycles = 0;
  int  mismatches = 0;
  int  results_seen = 0;
  int  stim_count = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  drain_next = 1'b0;

  // Configuration as the block holds it.
  logic [BYTE_W-1:0]  open_code;
  logic [BYTE_W-1:0]  end_code;
  logic               general_mode;
  logic [TIMER_W-1:0] frame_timeout;
  logic [TIMER_W-1:0] link_timeout;

  // Deframer state as predicted from the accepted items.
  bit                 in_frame;
  bit                 link_up;
  bit                 frame_overflow;
  logic [TIMER_W-1:0] frame_left;
  logic [TIMER_W-1:0] link_left;
  int                 frame_len;
  logic [BYTE_W-1:0]  frame_bytes [FRAME_DEPTH];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // A hung handshake must not keep the run alive forever.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch at cycle %0d: %s", cycles, what);
    end
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                results_seen, name, got, want));
    end
  endtask

  // Every result carries the link state as it stands once the item is handled.
  function automatic void queue_result(kind_t kind, int ptype, int dlen, int dbyte, int idx,
                                       bit last, logic [ERR_W-1:0] err);
    out_item_t r;
    r.kind   = kind;
    r.ptype  = PTYPE_W'(ptype);
    r.dlen   = DLEN_W'(dlen);
    r.dbyte  = BYTE_W'(dbyte);
    r.idx    = IDX_W'(idx);
    r.last   = last;
    r.online = link_up;
    r.err    = err;
    expected_results.push_back(r);
  endfunction

  function automatic void leave_frame();
    in_frame       = 1'b0;
    frame_len      = 0;
    frame_overflow = 1'b0;
  endfunction

  // Advances the predicted state by one accepted item and queues its results.
  function automatic void deframe_step(logic [OPCODE_W-1:0] op, logic [BYTE_W-1:0] b,
                                       logic [ERR_W-1:0] errs);
    bit good;
    int ptype;
    int dlen;
    int i;
    ptype = 0;
    dlen  = 0;
    case (op_t'(op))
      OP_BYTE: begin
        if (!in_frame) begin
          // While hunting, everything but the opening code is dropped.
          if (b == open_code) begin
            frame_bytes[0] = b;
            frame_len      = 1;
            frame_overflow = 1'b0;
            frame_left     = frame_timeout;
            in_frame       = 1'b1;
          end
        end else begin
          // Inside a frame even the opening code is an ordinary byte; bytes past
          // the store depth are lost and mark the frame as overlong.
          if (frame_len < FRAME_DEPTH) begin
            frame_bytes[frame_len] = b;
            frame_len++;
          end else begin
            frame_overflow = 1'b1;
          end
          if (b == end_code) begin
            good = !frame_overflow && frame_len >= FRAME_OVERHEAD;
            for (i = 1; i <= HDR_BYTES; i++) begin
              if (frame_bytes[i] < ASCII_ZERO || frame_bytes[i] > ASCII_ZERO + 8'd9) begin
                good = 1'b0;
              end
            end
            if (good) begin
              ptype = int'(frame_bytes[1] - ASCII_ZERO) * 10 + int'(frame_bytes[2] - ASCII_ZERO);
              dlen  = int'(frame_bytes[3] - ASCII_ZERO) * 10 + int'(frame_bytes[4] - ASCII_ZERO);
              if (general_mode) begin
                good = dlen <= MAX_PAYLOAD;
              end else begin
                good = (ptype == FIX_TYPE_A && dlen == FIX_LEN_A) ||
                       (ptype == FIX_TYPE_B && dlen == FIX_LEN_B);
              end
              if (good && frame_len != dlen + FRAME_OVERHEAD) begin
                good = 1'b0;
              end
            end
            if (good) begin
              link_up   = 1'b1;
              link_left = link_timeout;
              if (dlen == 0) begin
                // An empty payload still produces one data result.
                queue_result(KIND_DATA, ptype, 0, 0, 0, 1'b1, '0);
              end else begin
                for (i = 0; i < dlen; i++) begin
                  queue_result(KIND_DATA, ptype, dlen, frame_bytes[PAYLOAD_OFFSET + i], i,
                               i == dlen - 1, '0);
                end
              end
            end else begin
              queue_result(KIND_BAD_FRAME, 0, 0, 0, 0, 1'b1, '0);
            end
            leave_frame();
          end
        end
      end
      OP_TICK: begin
        // A stalled frame is dropped without a result once its countdown runs out.
        if (in_frame) begin
          if (frame_left <= 1) begin
            frame_left = '0;
            leave_frame();
          end else begin
            frame_left--;
          end
        end
        if (link_up) begin
          if (link_left == 0) begin
            link_up = 1'b0;
            queue_result(KIND_OFFLINE, 0, 0, 0, 0, 1'b1, '0);
          end else begin
            link_left--;
          end
        end
      end
      OP_LINE_ERR: begin
        if (errs != 0) begin
          queue_result(KIND_LINE_ERR, 0, 0, 0, 0, 1'b1, errs);
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Sender: offers the next item from the queue, idling at random, and hands
  // every accepted item to the predictor at the edge where it is taken.
  always @(posedge clk) begin : feed_link
    line_event_t nxt;
    if (!rst_n) begin
      in_ch.valid      <= 1'b0;
      in_ch.opcode     <= OP_NONE;
      in_ch.rx_byte    <= '0;
      in_ch.error_bits <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        deframe_step(in_ch.opcode, in_ch.rx_byte, in_ch.error_bits);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (rx_events.size() != 0 &&
            !(rx_events[0].drain && expected_results.size() != 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          nxt = rx_events.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.opcode     <= nxt.opcode;
          in_ch.rx_byte    <= nxt.rx_byte;
          in_ch.error_bits <= nxt.error_bits;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compares each taken result with the oldest expectation and
  // stalls at random.
  always @(posedge clk) begin : take_results
    out_item_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = expected_results.pop_front();
          check_field("kind", out_ch.kind, want.kind);
          check_field("packet_type", out_ch.packet_type, want.ptype);
          check_field("data_length", out_ch.data_length, want.dlen);
          check_field("data_byte", out_ch.data_byte, want.dbyte);
          check_field("byte_index", out_ch.byte_index, want.idx);
          check_field("last", out_ch.last, want.last);
          check_field("online", out_ch.online, want.online);
          check_field("error_code", out_ch.error_code, want.err);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Queues one item. Items the block only ignores are not counted.
  function automatic void add_event(op_t op, logic [BYTE_W-1:0] b, logic [ERR_W-1:0] errs,
                                    bit counted);
    line_event_t ev;
    ev.opcode     = op;
    ev.rx_byte    = b;
    ev.error_bits = errs;
    ev.drain      = drain_next;
    drain_next    = 1'b0;
    rx_events.push_back(ev);
    if (counted) begin
      stim_count++;
    end
  endfunction

  function automatic void add_byte(logic [BYTE_W-1:0] b);
    add_event(OP_BYTE, b, ERR_W'($urandom_range(3)), 1'b1);
  endfunction

  function automatic void add_tick();
    add_event(OP_TICK, BYTE_W'($urandom_range(255)), ERR_W'($urandom_range(3)), 1'b1);
  endfunction

  // Payload bytes avoid the end code so that the frame does not close early.
  function automatic logic [BYTE_W-1:0] payload_byte();
    logic [BYTE_W-1:0] b;
    do begin
      b = BYTE_W'($urandom_range(255));
    end while (b == end_code);
    return b;
  endfunction

  // Builds one frame of the given shape for the current configuration.
  // Optional ticks are scattered between its bytes to exercise the frame timeout.
  function automatic void add_frame(frame_shape_t shape, bit stray_ticks);
    logic [BYTE_W-1:0] body[$];
    int ptype;
    int dlen;
    int n;
    int pos;
    int k;
    if (general_mode) begin
      ptype = $urandom_range(99);
      dlen  = $urandom_range(MAX_PAYLOAD);
    end else if ($urandom_range(1)) begin
      ptype = FIX_TYPE_A;
      dlen  = FIX_LEN_A;
    end else begin
      ptype = FIX_TYPE_B;
      dlen  = FIX_LEN_B;
    end
    if (shape == FRAME_BAD_PAIR) begin
      if (general_mode) begin
        dlen = $urandom_range(99, MAX_PAYLOAD + 1);
      end else begin
        do begin
          ptype = $urandom_range(3);
          dlen  = $urandom_range(MAX_PAYLOAD);
        end while ((ptype == FIX_TYPE_A && dlen == FIX_LEN_A) ||
                   (ptype == FIX_TYPE_B && dlen == FIX_LEN_B));
      end
    end
    body.push_back(ASCII_ZERO + BYTE_W'(ptype / 10));
    body.push_back(ASCII_ZERO + BYTE_W'(ptype % 10));
    body.push_back(ASCII_ZERO + BYTE_W'(dlen / 10));
    body.push_back(ASCII_ZERO + BYTE_W'(dlen % 10));
    n = dlen;
    case (shape)
      FRAME_WRONG_LEN: begin
        do begin
          n = $urandom_range(MAX_PAYLOAD);
        end while (n == dlen);
      end
      FRAME_OVERLONG: n = $urandom_range(FRAME_DEPTH + 4, FRAME_DEPTH - FRAME_OVERHEAD + 1);
      FRAME_BAD_PAIR: begin
        if (n > MAX_PAYLOAD) begin
          n = $urandom_range(MAX_PAYLOAD);
        end
      end
      default: begin
      end
    endcase
    for (k = 0; k < n; k++) begin
      body.push_back(payload_byte());
    end
    if (shape == FRAME_NONDIGIT) begin
      // Bytes below ASCII zero are the interesting side of the digit check.
      pos = $urandom_range(HDR_BYTES - 1);
      do begin
        if ($urandom_range(1)) begin
          body[pos] = BYTE_W'($urandom_range(ASCII_ZERO - 1));
        end else begin
          body[pos] = BYTE_W'($urandom_range(255, ASCII_ZERO + 10));
        end
      end while (body[pos] == end_code);
    end
    if (shape == FRAME_SHORT) begin
      k = $urandom_range(HDR_BYTES - 1);
      while (body.size() > k) begin
        void'(body.pop_back());
      end
    end
    add_byte(open_code);
    foreach (body[j]) begin
      if (stray_ticks && $urandom_range(3) == 0) begin
        add_tick();
      end
      add_byte(body[j]);
    end
    add_byte(end_code);
  endfunction

  // Random traffic: mostly well formed frames with random content, plus broken
  // frames, idle noise, ticks, line errors and the unused opcode.
  function automatic void fill_random(int count);
    int target;
    int pick;
    target = stim_count + count;
    while (stim_count < target) begin
      pick = $urandom_range(99);
      if ($urandom_range(29) == 0) begin
        drain_next = 1'b1;
      end
      if (pick < 58) begin
        add_frame(FRAME_GOOD, $urandom_range(6) == 0);
      end else if (pick < 72) begin
        add_frame(frame_shape_t'($urandom_range(FRAME_BAD_PAIR, FRAME_SHORT)),
                  $urandom_range(3) == 0);
      end else if (pick < 80) begin
        repeat ($urandom_range(3, 1)) begin
          add_event(OP_BYTE, BYTE_W'($urandom_range(255)), ERR_W'($urandom_range(3)), 1'b0);
        end
      end else if (pick < 90) begin
        repeat ($urandom_range(4, 1)) begin
          add_tick();
        end
      end else if (pick < 97) begin
        add_event(OP_LINE_ERR, BYTE_W'($urandom_range(255)), ERR_W'($urandom_range(3)), 1'b1);
      end else begin
        add_event(OP_NONE, BYTE_W'($urandom_range(255)), ERR_W'($urandom_range(3)), 1'b0);
      end
    end
  endfunction

  // One register write on the configuration port; the predicted copy follows.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_OPEN_CODE:     open_code     = val[BYTE_W-1:0];
      REG_END_CODE:      end_code      = val[BYTE_W-1:0];
      REG_GENERAL_MODE:  general_mode  = val[0];
      REG_FRAME_TIMEOUT: frame_timeout = val;
      REG_LINK_TIMEOUT:  link_timeout  = val;
      default: begin
      end
    endcase
  endtask

  // Writes all five registers. Unused upper data bits carry random values,
  // which the narrow registers must drop.
  task automatic program_all(logic [BYTE_W-1:0] s, logic [BYTE_W-1:0] e, logic gm,
                             logic [TIMER_W-1:0] ft, logic [TIMER_W-1:0] lt);
    write_reg(REG_OPEN_CODE, {BYTE_W'($urandom), s});
    write_reg(REG_END_CODE, {BYTE_W'($urandom), e});
    write_reg(REG_GENERAL_MODE, {(CFG_DATA_W - 1)'($urandom), gm});
    write_reg(REG_FRAME_TIMEOUT, ft);
    write_reg(REG_LINK_TIMEOUT, lt);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every queued item was accepted and every expected result taken,
  // then lets the block settle so that items without results are finished too.
  task automatic wait_drained();
    int spins;
    spins = 0;
    do begin
      @(negedge clk);
      spins++;
    end while ((rx_events.size() != 0 || in_ch.valid || expected_results.size() != 0) &&
               spins < DRAIN_LIMIT);
    foreach (expected_results[j]) begin
      report_mismatch($sformatf("expected result of kind %0d never arrived",
                                expected_results[j].kind));
    end
    expected_results.delete();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [BYTE_W-1:0] s;
    logic [BYTE_W-1:0] e;

    // Reset is held and the configuration port is quiet from the start; the
    // channel signals get their values from the sender and receiver in reset.
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_OPEN_CODE;
    cfg_data  <= '0;

    // The prediction starts from the reset state of the block.
    open_code      = OPEN_CODE_RST;
    end_code       = END_CODE_RST;
    general_mode   = GENERAL_MODE_RST;
    frame_timeout  = FRAME_TIMEOUT_RST;
    link_timeout   = LINK_TIMEOUT_RST;
    in_frame       = 1'b0;
    link_up        = 1'b0;
    frame_overflow = 1'b0;
    frame_left     = '0;
    link_left      = '0;
    frame_len      = 0;
    foreach (frame_bytes[j]) begin
      frame_bytes[j] = '0;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // First stretch of the run: sender idles often, receiver even more.
    send_idle_pct = 36;
    recv_idle_pct = 58;

    // Reset configuration: fixed type/length pairs, long timeouts.
    fill_random(24);
    wait_drained();

    // Directed part with shortest timeouts and general mode on.
    program_all(OPEN_CODE_RST, END_CODE_RST, 1'b1, 16'd1, 16'd1);
    add_event(OP_NONE, 8'hFF, 2'b11, 1'b0);
    add_event(OP_LINE_ERR, 8'h00, 2'b00, 1'b1);
    add_event(OP_LINE_ERR, 8'hA5, 2'b11, 1'b1);
    // Largest type with the extreme payload byte values.
    add_byte(open_code);
    add_byte(ASCII_ZERO + 8'd9);
    add_byte(ASCII_ZERO + 8'd9);
    add_byte(ASCII_ZERO);
    add_byte(ASCII_ZERO + 8'd2);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(end_code);
    // The link countdown of one tick runs out on the second tick.
    add_tick();
    add_tick();
    // Empty payload, offered only once the sender has seen all results.
    drain_next = 1'b1;
    add_byte(open_code);
    repeat (HDR_BYTES) add_byte(ASCII_ZERO);
    add_byte(end_code);
    // The opening code inside a frame is data; one tick then abandons the frame,
    // so the end code that follows is dropped while hunting.
    add_byte(open_code);
    add_byte(open_code);
    add_tick();
    add_byte(end_code);
    wait_drained();

    // Highest opening code, lowest end code, longest frame timeout.
    program_all(8'hFF, 8'h00, 1'b1, 16'hFFFF, 16'd3);
    fill_random(48);
    wait_drained();

    // Second stretch: the receiver is now the faster side.
    send_idle_pct = 58;
    recv_idle_pct = 36;

    // Lowest opening code, highest end code, fixed pairs, longest link timeout.
    // The indexes past the last register are written too and must do nothing.
    program_all(8'h00, 8'hFF, 1'b0, 16'd3, 16'hFFFF);
    for (int k = int'(REG_LINK_TIMEOUT) + 1; k < (1 << CFG_IDX_W); k++) begin
      write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    fill_random(48);
    wait_drained();

    program_all(8'h5B, 8'h5D, 1'b1, 16'd6, 16'd2);
    fill_random(48);
    wait_drained();

    // Last stretch: neither side idles, and the codes are random.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    s = BYTE_W'($urandom_range(255));
    do begin
      e = BYTE_W'($urandom_range(255));
    end while (e == s || (e >= ASCII_ZERO && e <= ASCII_ZERO + 8'd9));
    program_all(s, e, 1'($urandom_range(1)), TIMER_W'($urandom_range(12, 2)),
                TIMER_W'($urandom_range(6, 1)));
    fill_random(48);
    wait_drained();

    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
